@@ src/assert_macros.svh @@
// Assertion macros used by the checker file pfc_checker.sv. They expect clk_i and rst_ni in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define PFC_ASSERT_IMPL(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define PFC_ASSERT_NEXT(name, pre, post, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

@@ src/pfc_pkg.sv @@
package pfc_pkg;

  localparam int unsigned QUEUE_DEPTH = 2;

  localparam logic [2:0] ACT_CLEAR   = 3'd0;
  localparam logic [2:0] ACT_KEY     = 3'd1;
  localparam logic [2:0] ACT_FINISH  = 3'd2;
  localparam logic [2:0] ACT_ENCRYPT = 3'd3;
  localparam logic [2:0] ACT_DECRYPT = 3'd4;

  localparam logic [4:0] LETTER_I = 5'd8;
  localparam logic [4:0] LETTER_J = 5'd9;
  localparam logic [4:0] LETTER_Z = 5'd25;
  localparam logic [4:0] LETTERS  = 5'd26;
  localparam logic [4:0] CELLS    = 5'd25;
  localparam logic [2:0] SIDE_MAX = 3'd4;

  typedef enum logic [2:0] {
    OP_NOP,
    OP_CLEAR,
    OP_KEY,
    OP_FINISH,
    OP_PAIR
  } pfc_op_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_FILL,
    ST_CORNER,
    ST_EMIT
  } pfc_state_e;

  typedef struct packed {
    pfc_op_e    op;
    logic       decrypt;
    logic [4:0] letter_a;
    logic [4:0] letter_b;
  } pfc_cmd_t;

  typedef struct packed {
    logic [4:0] out_first;
    logic [4:0] out_second;
    logic       status;
  } pfc_res_t;

  // Row of a cell index 0..24 in the 5x5 square.
  function automatic logic [2:0] pfc_row(input logic [4:0] pos);
    logic [2:0] row;
    if (pos >= 5'd20) begin
      row = 3'd4;
    end else if (pos >= 5'd15) begin
      row = 3'd3;
    end else if (pos >= 5'd10) begin
      row = 3'd2;
    end else if (pos >= 5'd5) begin
      row = 3'd1;
    end else begin
      row = 3'd0;
    end
    return row;
  endfunction

  function automatic logic [4:0] pfc_cell(input logic [2:0] row, input logic [2:0] col);
    logic [4:0] base;
    base = {row, 2'b00} + 5'(row);
    return base + 5'(col);
  endfunction

  function automatic logic [2:0] pfc_col(input logic [4:0] pos);
    logic [4:0] base;
    base = pfc_cell(pfc_row(pos), 3'd0);
    return 3'(pos - base);
  endfunction

  // One step along a row or column with wrap; decrypt steps backward.
  function automatic logic [2:0] pfc_step(input logic [2:0] v, input logic decrypt);
    logic [2:0] r;
    if (decrypt) begin
      r = (v == 3'd0) ? SIDE_MAX : v - 3'd1;
    end else begin
      r = (v == SIDE_MAX) ? 3'd0 : v + 3'd1;
    end
    return r;
  endfunction

endpackage

@@ src/pfc_if.sv @@
interface pfc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] action;
  logic [4:0] first_letter;
  logic [4:0] second_letter;

  modport source (output valid, output action, output first_letter, output second_letter,
                  input ready);
  modport sink (input valid, input action, input first_letter, input second_letter,
                output ready);
endinterface

interface pfc_out_if;
  logic       valid;
  logic       ready;
  logic [4:0] out_first;
  logic [4:0] out_second;
  logic       status;

  modport source (output valid, output out_first, output out_second, output status,
                  input ready);
  modport sink (input valid, input out_first, input out_second, input status,
                output ready);
endinterface

@@ src/pfc_front.sv @@
module pfc_front (
  pfc_in_if.sink             in_i,
  output pfc_pkg::pfc_cmd_t  cmd_o,
  output logic               cmd_valid_o,
  input  logic               cmd_ready_i
);

  logic [4:0] sat_a;
  logic [4:0] sat_b;

  assign in_i.ready  = cmd_ready_i;
  assign cmd_valid_o = in_i.valid;

  always_comb begin
    sat_a = (in_i.first_letter > pfc_pkg::LETTER_Z) ? pfc_pkg::LETTER_Z : in_i.first_letter;
    sat_b = (in_i.second_letter > pfc_pkg::LETTER_Z) ? pfc_pkg::LETTER_Z : in_i.second_letter;

    cmd_o.op       = pfc_pkg::OP_NOP;
    cmd_o.decrypt  = 1'b0;
    // The letter j shares the cell of i, both in the key and in pairs.
    cmd_o.letter_a = (sat_a == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : sat_a;
    cmd_o.letter_b = (sat_b == pfc_pkg::LETTER_J) ? pfc_pkg::LETTER_I : sat_b;

    unique case (in_i.action) inside
      pfc_pkg::ACT_CLEAR: begin
        cmd_o.op = pfc_pkg::OP_CLEAR;
      end
      pfc_pkg::ACT_KEY: begin
        // A key letter outside a to z leaves the square alone.
        cmd_o.op = (in_i.first_letter < pfc_pkg::LETTERS) ? pfc_pkg::OP_KEY : pfc_pkg::OP_NOP;
      end
      pfc_pkg::ACT_FINISH: begin
        cmd_o.op = pfc_pkg::OP_FINISH;
      end
      pfc_pkg::ACT_ENCRYPT, pfc_pkg::ACT_DECRYPT: begin
        cmd_o.op      = pfc_pkg::OP_PAIR;
        cmd_o.decrypt = (in_i.action == pfc_pkg::ACT_DECRYPT);
      end
      default: begin
        cmd_o.op = pfc_pkg::OP_NOP;
      end
    endcase
  end

endmodule

@@ src/pfc_queue.sv @@
module pfc_queue #(
  parameter int unsigned Depth = pfc_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfc_pkg::pfc_cmd_t  push_data_i,
  input  logic               push_valid_i,
  output logic               push_ready_o,
  output pfc_pkg::pfc_cmd_t  pop_data_o,
  output logic               pop_valid_o,
  input  logic               pop_i
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] Full    = CntW'(Depth);

  pfc_pkg::pfc_cmd_t entry_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]   count_q, count_d;
  logic              push;
  logic              pop;

  assign push_ready_o = (count_q != Full);
  assign pop_valid_o  = (count_q != '0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_i && pop_valid_o;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

@@ src/pfc_back.sv @@
module pfc_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  pfc_pkg::pfc_cmd_t  cmd_i,
  input  logic               cmd_valid_i,
  output logic               cmd_pop_o,
  output pfc_pkg::pfc_res_t  res_o,
  output logic               res_valid_o,
  input  logic               res_ready_i
);

  pfc_pkg::pfc_state_e state_q, state_d;
  logic [25:0]         letter_used_q, letter_used_d;
  logic [4:0]          fill_count_q, fill_count_d;
  logic                key_ready_q, key_ready_d;
  logic [4:0]          fill_letter_q, fill_letter_d;
  logic                out_valid_q, out_valid_d;
  pfc_pkg::pfc_res_t   out_q;
  pfc_pkg::pfc_res_t   res_q, res_d;
  logic                decrypt_q;
  logic [4:0]          pos_a_q, pos_b_q;

  logic [4:0] key_square_q [25];
  logic [4:0] letter_pos_q [26];

  logic       place_en;
  logic       place_ok;
  logic [4:0] place_letter;
  logic       pos_rd;
  logic       sq_rd;
  logic       res_ld;
  logic       out_load;

  logic [2:0] row_a, col_a, row_b, col_b;
  logic [2:0] nrow_a, ncol_a, nrow_b, ncol_b;
  logic [4:0] cell_a, cell_b;

  assign place_ok = place_en && (fill_count_q < pfc_pkg::CELLS)
                    && !letter_used_q[place_letter];

  // Digraph rules on the two looked-up positions.
  always_comb begin
    row_a  = pfc_pkg::pfc_row(pos_a_q);
    col_a  = pfc_pkg::pfc_col(pos_a_q);
    row_b  = pfc_pkg::pfc_row(pos_b_q);
    col_b  = pfc_pkg::pfc_col(pos_b_q);
    nrow_a = row_a;
    ncol_a = col_a;
    nrow_b = row_b;
    ncol_b = col_b;
    if (row_a == row_b) begin
      ncol_a = pfc_pkg::pfc_step(col_a, decrypt_q);
      ncol_b = pfc_pkg::pfc_step(col_b, decrypt_q);
    end else if (col_a == col_b) begin
      nrow_a = pfc_pkg::pfc_step(row_a, decrypt_q);
      nrow_b = pfc_pkg::pfc_step(row_b, decrypt_q);
    end else begin
      ncol_a = col_b;
      ncol_b = col_a;
    end
    cell_a = pfc_pkg::pfc_cell(nrow_a, ncol_a);
    cell_b = pfc_pkg::pfc_cell(nrow_b, ncol_b);
  end

  always_comb begin
    state_d       = state_q;
    letter_used_d = letter_used_q;
    fill_count_d  = fill_count_q;
    key_ready_d   = key_ready_q;
    fill_letter_d = fill_letter_q;
    cmd_pop_o     = 1'b0;
    place_en      = 1'b0;
    place_letter  = cmd_i.letter_a;
    pos_rd        = 1'b0;
    sq_rd         = 1'b0;
    res_ld        = 1'b0;
    res_d         = '0;
    out_load      = 1'b0;

    unique case (state_q)
      pfc_pkg::ST_IDLE: begin
        if (cmd_valid_i) begin
          cmd_pop_o = 1'b1;
          state_d   = pfc_pkg::ST_EMIT;
          res_ld    = 1'b1;
          unique case (cmd_i.op)
            pfc_pkg::OP_CLEAR: begin
              letter_used_d = '0;
              fill_count_d  = '0;
              key_ready_d   = 1'b0;
            end
            pfc_pkg::OP_KEY: begin
              place_en = 1'b1;
            end
            pfc_pkg::OP_FINISH: begin
              fill_letter_d = '0;
              state_d       = pfc_pkg::ST_FILL;
              res_ld        = 1'b0;
            end
            pfc_pkg::OP_PAIR: begin
              if (!key_ready_q) begin
                res_d.status = 1'b1;
              end else begin
                pos_rd  = 1'b1;
                res_ld  = 1'b0;
                state_d = pfc_pkg::ST_CORNER;
              end
            end
            pfc_pkg::OP_NOP: begin
            end
            default: begin
            end
          endcase
        end
      end
      pfc_pkg::ST_FILL: begin
        // Walk a to z once, placing every letter but j that the key did not use.
        place_en     = (fill_letter_q != pfc_pkg::LETTER_J);
        place_letter = fill_letter_q;
        if (fill_letter_q == pfc_pkg::LETTER_Z) begin
          key_ready_d = 1'b1;
          res_ld      = 1'b1;
          state_d     = pfc_pkg::ST_EMIT;
        end else begin
          fill_letter_d = fill_letter_q + 5'd1;
        end
      end
      pfc_pkg::ST_CORNER: begin
        sq_rd   = 1'b1;
        state_d = pfc_pkg::ST_EMIT;
      end
      pfc_pkg::ST_EMIT: begin
        if (!out_valid_q || res_ready_i) begin
          out_load = 1'b1;
          state_d  = pfc_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = pfc_pkg::ST_IDLE;
      end
    endcase

    if (place_ok) begin
      letter_used_d[place_letter] = 1'b1;
      fill_count_d                = fill_count_q + 5'd1;
    end
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (res_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= pfc_pkg::ST_IDLE;
      letter_used_q <= '0;
      fill_count_q  <= '0;
      key_ready_q   <= 1'b0;
      fill_letter_q <= '0;
      out_valid_q   <= 1'b0;
    end else begin
      state_q       <= state_d;
      letter_used_q <= letter_used_d;
      fill_count_q  <= fill_count_d;
      key_ready_q   <= key_ready_d;
      fill_letter_q <= fill_letter_d;
      out_valid_q   <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (place_ok) begin
      key_square_q[fill_count_q] <= place_letter;
      letter_pos_q[place_letter] <= fill_count_q;
    end
    if (pos_rd) begin
      pos_a_q   <= letter_pos_q[cmd_i.letter_a];
      pos_b_q   <= letter_pos_q[cmd_i.letter_b];
      decrypt_q <= cmd_i.decrypt;
    end
    if (sq_rd) begin
      res_q.out_first  <= key_square_q[cell_a];
      res_q.out_second <= key_square_q[cell_b];
      res_q.status     <= 1'b0;
    end else if (res_ld) begin
      res_q <= res_d;
    end
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign res_o       = out_q;
  assign res_valid_o = out_valid_q;

endmodule

@@ src/playfair_digraph_cipher.sv @@
// Playfair cipher over a 5x5 key square, one result word per input word. A clear word
// starts a new key, key-letter words place letters in order (j counts as i, repeats are
// dropped), and a finish word fills the remaining cells with the unused letters and
// arms the square; pair words then encrypt or decrypt two letters, or return status 1
// while the square is not armed. Input words pass a classifier into a small queue
// (QueueDepth words), so the input keeps accepting while the sequencer behind it works.
// The sequencer handles one word at a time: clear, key-letter and unused words go
// straight to the result stage, pair words pass position lookup, then square lookup,
// then the result stage, and a finish word walks a to z one letter per cycle through the
// single write port of the key square before its result stage. Results leave through an
// output register that holds a word until it is taken.
module playfair_digraph_cipher #(
  parameter int unsigned QueueDepth = pfc_pkg::QUEUE_DEPTH
) (
  input logic        clk_i,
  input logic        rst_ni,
  pfc_in_if.sink     in_i,
  pfc_out_if.source  out_o
);

  pfc_pkg::pfc_cmd_t front_cmd;
  logic              front_valid;
  logic              front_ready;
  pfc_pkg::pfc_cmd_t queue_cmd;
  logic              queue_valid;
  logic              queue_pop;
  pfc_pkg::pfc_res_t res;
  logic              res_valid;

  pfc_front u_front (
    .in_i        (in_i),
    .cmd_o       (front_cmd),
    .cmd_valid_o (front_valid),
    .cmd_ready_i (front_ready)
  );

  pfc_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_data_i  (front_cmd),
    .push_valid_i (front_valid),
    .push_ready_o (front_ready),
    .pop_data_o   (queue_cmd),
    .pop_valid_o  (queue_valid),
    .pop_i        (queue_pop)
  );

  pfc_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (queue_cmd),
    .cmd_valid_i (queue_valid),
    .cmd_pop_o   (queue_pop),
    .res_o       (res),
    .res_valid_o (res_valid),
    .res_ready_i (out_o.ready)
  );

  assign out_o.valid      = res_valid;
  assign out_o.out_first  = res.out_first;
  assign out_o.out_second = res.out_second;
  assign out_o.status     = res.status;

endmodule

@@ src/pfc_checker.sv @@
`include "assert_macros.svh"

module pfc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [4:0] out_first_i,
  input logic [4:0] out_second_i,
  input logic       status_i
);

  // Words accepted but not yet delivered.
  logic [7:0] pending_q;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid_i && in_ready_i;
  assign out_acc = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 8'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 8'd1;
    end
  end

  `PFC_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i,
                   out_valid_i && $stable(out_first_i) && $stable(out_second_i)
                   && $stable(status_i), "stalled result changed")
  `PFC_ASSERT_IMPL(a_no_extra_result, out_valid_i, pending_q != 8'd0,
                   "result without an accepted word")
  `PFC_ASSERT_IMPL(a_stall_when_busy, !in_ready_i, pending_q != 8'd0,
                   "input stalled while nothing is pending")

endmodule

bind playfair_digraph_cipher pfc_checker u_pfc_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_first_i  (out_o.out_first),
  .out_second_i (out_o.out_second),
  .status_i     (out_o.status)
);
